// ----- hw/rtl/lgri_pkg.sv -----
// Shared types, constants and codes for the lat/lon radius grid interpolator.
`timescale 1ns / 1ps
package lgri_pkg;

	localparam int FRAC_W      = 16;
	localparam int ANGLE_W     = 32;
	localparam int RADIUS_W    = 32;
	localparam int MAX_ROWS    = 128;
	localparam int MAX_COLUMNS = 256;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int GRID_DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int LAT_PTS_W   = 8;
	localparam int LON_PTS_W   = 9;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int UNIT    = 1 << FRAC_W;
	localparam int HALF    = 1 << (FRAC_W - 1);
	localparam int DEG90   = 90 * UNIT;
	localparam int DEG180  = 180 * UNIT;
	localparam int DEG270  = 270 * UNIT;
	localparam int DEG360  = 360 * UNIT;
	localparam int DEG450  = 450 * UNIT;
	// pole tolerance: 90 degrees plus 0.01 degree on the fixed-point grid
	localparam int POLE_TOL = DEG90 + (UNIT + 50) / 100;
	// multiple of 360 degrees that lifts any longitude above zero
	localparam longint LON_BIAS = 92 * longint'(DEG360);

	// reciprocals: n/360 = (n*MOD_RECIP)>>25, n/180 = (n*MOD_RECIP)>>24
	localparam int MOD_RECIP   = 93207;
	localparam int SH_DIV360   = 25;
	localparam int SH_DIV180   = 24;
	// weight reciprocals: r/180 = (r*W_RECIP180)>>32, r/360 = (r*W_RECIP360)>>34
	localparam int W_RECIP180  = 23860930;
	localparam int W_RECIP360  = 47721859;
	localparam int SH_W180     = 32;
	localparam int SH_W360     = 34;

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_BILINEAR = 2'd1,
		CMD_NEAREST  = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_BILINEAR = 2'd1,
		KIND_NEAREST  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAT_POINTS = 1'b0,
		REG_LON_POINTS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [ANGLE_W-1:0] lat;
		logic signed [ANGLE_W-1:0] lon;
		logic [ADDR_W-1:0]         waddr;
		logic [RADIUS_W-1:0]       wdata;
	} item_t;

	// grid extent minus one in each direction
	typedef struct packed {
		logic [ROW_W-1:0] lat_span;
		logic [COL_W-1:0] lon_span;
	} dims_t;

endpackage

// ----- hw/rtl/lgri_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lgri_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/lgri_front.sv -----
// Front end: takes input transactions, decodes the command, drops unused codes.
`timescale 1ns / 1ps
module lgri_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [1:0]                        command,
	input  logic signed [lgri_pkg::ANGLE_W-1:0] lat_angle,
	input  logic signed [lgri_pkg::ANGLE_W-1:0] lon_angle,
	input  logic [lgri_pkg::ROW_W-1:0]        row_index,
	input  logic [lgri_pkg::COL_W-1:0]        column_index,
	input  logic [lgri_pkg::RADIUS_W-1:0]     sample_value,
	output logic                              push,
	output lgri_pkg::item_t                   push_item,
	input  logic                              q_full
);
	import lgri_pkg::*;

	logic  fr_valid_q;
	item_t fr_item_q;
	kind_t kind;
	logic  keep;
	logic  accept;

	always_comb begin
		kind = KIND_WRITE;
		keep = 1'b1;
		unique case (cmd_t'(command))
			CMD_WRITE:    kind = KIND_WRITE;
			CMD_BILINEAR: kind = KIND_BILINEAR;
			CMD_NEAREST:  kind = KIND_NEAREST;
			default:      keep = 1'b0;
		endcase
	end

	assign item_stall = fr_valid_q && q_full;
	assign accept     = item_valid && !item_stall;
	assign push       = fr_valid_q && !q_full;
	assign push_item  = fr_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (accept) begin
			fr_valid_q <= keep;
		end else if (push) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_item_q.kind  <= kind;
			fr_item_q.lat   <= lat_angle;
			fr_item_q.lon   <= lon_angle;
			fr_item_q.waddr <= {row_index, column_index};
			fr_item_q.wdata <= sample_value;
		end
	end

endmodule

// ----- hw/rtl/lgri_queue.sv -----
// Short FIFO between the front end and the lookup pipeline.
`timescale 1ns / 1ps
module lgri_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lgri_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output lgri_pkg::item_t head,
	output logic            empty
);
	import lgri_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hw/rtl/lgri_back.sv -----
// Lookup pipeline: angle folding, grid indexing, grid store, bilinear blend.
`timescale 1ns / 1ps
module lgri_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lgri_pkg::item_t               q_item,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  lgri_pkg::dims_t               dims,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lgri_pkg::RADIUS_W-1:0] radius_out
);
	import lgri_pkg::*;

	typedef struct packed {
		logic                vld;
		kind_t               kind;
		logic [ADDR_W-1:0]   waddr;
		logic [RADIUS_W-1:0] wdata;
	} tag_t;

	localparam int NSTAGE = 11;

	localparam logic signed [33:0] S_D90  = 34'(DEG90);
	localparam logic signed [33:0] S_D180 = 34'(DEG180);
	localparam logic signed [33:0] S_D270 = 34'(DEG270);
	localparam logic signed [33:0] S_D360 = 34'(DEG360);
	localparam logic signed [33:0] S_D450 = 34'(DEG450);
	localparam logic signed [33:0] S_TOL  = 34'(POLE_TOL);
	localparam logic signed [33:0] S_BIAS = 34'(LON_BIAS);

	logic adv;
	logic out_valid_q;
	logic [RADIUS_W-1:0] radius_q;
	tag_t tag_s [1:NSTAGE];

	// stage 1
	logic signed [ANGLE_W-1:0] lat_s1, lon_s1;
	logic signed [33:0] lat_x1, lon_x1, lat_arg, lon_arg;
	logic lt1, gt1, fold1;
	// stage 2
	logic [33:0] pla_s2, plo_s2;
	logic [16:0] nla_s2, nlo_s2;
	logic [FRAC_W-1:0] fla_s2, flo_s2;
	logic lt_s2, gt_s2, fold_s2;
	logic signed [ANGLE_W-1:0] lat_s2, lon_s2;
	logic [8:0]  qla, qlo;
	logic [16:0] rla_f, rlo_f, rla, rlo;
	// stage 3
	logic [24:0] ma_s3, mo_s3;
	logic lt_s3, gt_s3, fold_s3;
	logic signed [ANGLE_W-1:0] lat_s3, lon_s3;
	logic signed [33:0] ma_x, l1, l2, l3a, l3, lc, lat_off;
	logic refl_a, refl_b;
	logic [25:0] lon_t;
	logic [24:0] lon_f;
	// stage 4
	logic [23:0] lato_s4;
	logic [24:0] lonf_s4;
	logic near4;
	// stage 5
	logic [31:0] u_s5;
	logic [33:0] v_s5;
	// stage 6
	logic [32:0] pu_s6;
	logic [34:0] pv_s6;
	logic [15:0] nu_s6;
	logic [17:0] nv_s6;
	logic [FRAC_W-1:0] fu_s6, fv_s6;
	logic [8:0]  qu;
	logic [9:0]  qv;
	logic [15:0] ru_f, ru;
	logic [17:0] rv_f, rv;
	// stage 7
	logic [ROW_W-1:0] ilat_s7, ila1;
	logic [COL_W-1:0] ilon_s7, ilo1;
	logic [23:0] remu_s7;
	logic [24:0] remv_s7;
	logic [ADDR_W-1:0] rd_addr [4];
	logic [RADIUS_W-1:0] rd_data [4];
	logic wr_en;
	// stage 8
	logic [48:0] wlp_s8;
	logic [50:0] wop_s8;
	logic [FRAC_W-1:0] wl8, wo8;
	logic [FRAC_W:0] woc8;
	// stage 9
	logic [48:0] p00_s9, p01_s9, p10_s9, p11_s9;
	logic [FRAC_W-1:0] wl_s9;
	logic [RADIUS_W-1:0] d0_s9;
	logic [49:0] s0, s1;
	// stage 10
	logic [RADIUS_W-1:0] r0_s10, r1_s10, d0_s10;
	logic [FRAC_W-1:0] wl_s10;
	// stage 11
	logic [48:0] q0_s11, q1_s11;
	logic [RADIUS_W-1:0] d0_s11;
	logic [49:0] s2;
	logic [RADIUS_W-1:0] res11;

	// whole pipeline halts while the output register is full and stalled
	assign adv          = !out_valid_q || !result_stall;
	assign q_pop        = adv && !q_empty;
	assign result_valid = out_valid_q;
	assign radius_out   = radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NSTAGE; i++) begin
				tag_s[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			tag_s[1].vld   <= q_pop;
			tag_s[1].kind  <= q_item.kind;
			tag_s[1].waddr <= q_item.waddr;
			tag_s[1].wdata <= q_item.wdata;
			for (int i = 2; i <= NSTAGE; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
			out_valid_q <= tag_s[NSTAGE].vld && (tag_s[NSTAGE].kind != KIND_WRITE);
		end
	end

	// stage 1: pole flags and operands of the two mod-360 reductions
	always_comb begin
		lat_x1  = {{2{lat_s1[ANGLE_W-1]}}, lat_s1};
		lon_x1  = {{2{lon_s1[ANGLE_W-1]}}, lon_s1};
		lt1     = lat_x1 < -S_TOL;
		gt1     = lat_x1 > S_TOL;
		fold1   = (lat_x1 < -S_D90) || (lat_x1 > S_D90) || lon_s1[ANGLE_W-1] ||
			(lon_x1 > S_D360);
		lat_arg = lt1 ? (S_D90 - lat_x1) : (lat_x1 - S_D90);
		lon_arg = lon_x1 + S_BIAS;
	end

	// stage 2: quotient correction
	always_comb begin
		qla   = pla_s2[SH_DIV360 +: 9];
		qlo   = plo_s2[SH_DIV360 +: 9];
		rla_f = nla_s2 - 17'(qla) * 17'd360;
		rlo_f = nlo_s2 - 17'(qlo) * 17'd360;
		rla   = (rla_f >= 17'd360) ? rla_f - 17'd360 : rla_f;
		rlo   = (rlo_f >= 17'd360) ? rlo_f - 17'd360 : rlo_f;
	end

	// stage 3: wrap, pole reflection, longitude reduction, clamp
	always_comb begin
		ma_x = $signed({9'd0, ma_s3});
		l1   = S_D450 - ma_x;
		if (lt_s3) begin
			if (l1 > S_TOL) begin
				l2 = (ma_s3 == '0) ? -S_D270 : (S_D90 - ma_x);
			end else begin
				l2 = l1;
			end
		end else if (gt_s3) begin
			l2 = ma_x - S_D270;
		end else begin
			l2 = {{2{lat_s3[ANGLE_W-1]}}, lat_s3};
		end
		refl_a = l2 < -S_TOL;
		l3a    = refl_a ? (-S_D180 - l2) : l2;
		refl_b = l3a > S_TOL;
		l3     = refl_b ? (S_D180 - l3a) : l3a;
		lon_t  = {1'b0, mo_s3} + ((refl_a ^ refl_b) ? 26'(DEG180) : 26'd0);
		lon_f  = (lon_t >= 26'(DEG360)) ? 25'(lon_t - 26'(DEG360)) : lon_t[24:0];
		if (!fold_s3) begin
			l3    = {{2{lat_s3[ANGLE_W-1]}}, lat_s3};
			lon_f = lon_s3[24:0];
		end
		lc      = (l3 < -S_D90) ? -S_D90 : ((l3 > S_D90) ? S_D90 : l3);
		lat_off = lc + S_D90;
	end

	assign near4 = (tag_s[4].kind == KIND_NEAREST);

	// stage 6: row/column quotient and remainder
	always_comb begin
		qu   = pu_s6[SH_DIV180 +: 9];
		qv   = pv_s6[SH_DIV360 +: 10];
		ru_f = nu_s6 - 16'(qu) * 16'd180;
		rv_f = nv_s6 - 18'(qv) * 18'd360;
		ru   = (ru_f >= 16'd180) ? ru_f - 16'd180 : ru_f;
		rv   = (rv_f >= 18'd360) ? rv_f - 18'd360 : rv_f;
	end

	// stage 7: neighbour indices and grid store access
	always_comb begin
		ila1 = (ilat_s7 < dims.lat_span) ? ilat_s7 + ROW_W'(1) : ilat_s7;
		ilo1 = (ilon_s7 < dims.lon_span) ? ilon_s7 + COL_W'(1) : ilon_s7;
		rd_addr[0] = {ilat_s7, ilon_s7};
		rd_addr[1] = {ilat_s7, ilo1};
		rd_addr[2] = {ila1, ilon_s7};
		rd_addr[3] = {ila1, ilo1};
		wr_en = adv && tag_s[7].vld && (tag_s[7].kind == KIND_WRITE);
	end

	// four copies of the grid so all four corners are read in the same cycle
	for (genvar b = 0; b < 4; b++) begin : g_bank
		lgri_ram #(
			.WIDTH(RADIUS_W),
			.DEPTH(GRID_DEPTH)
		) u_bank (
			.clk    (clk),
			.wr_en  (wr_en),
			.wr_addr(tag_s[7].waddr),
			.wr_data(tag_s[7].wdata),
			.rd_en  (adv),
			.rd_addr(rd_addr[b]),
			.rd_data(rd_data[b])
		);
	end

	assign wl8  = wlp_s8[SH_W180 +: FRAC_W];
	assign wo8  = wop_s8[SH_W360 +: FRAC_W];
	assign woc8 = (FRAC_W+1)'(UNIT) - (FRAC_W+1)'(wo8);

	assign s0 = 50'(p00_s9) + 50'(p01_s9) + 50'(HALF);
	assign s1 = 50'(p10_s9) + 50'(p11_s9) + 50'(HALF);
	assign s2 = 50'(q0_s11) + 50'(q1_s11) + 50'(HALF);
	assign res11 = (tag_s[11].kind == KIND_NEAREST) ? d0_s11 : s2[FRAC_W +: RADIUS_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1
			lat_s1 <= q_item.lat;
			lon_s1 <= q_item.lon;
			// s2
			nla_s2  <= {1'b0, lat_arg[31:FRAC_W]};
			fla_s2  <= lat_arg[FRAC_W-1:0];
			pla_s2  <= 34'({1'b0, lat_arg[31:FRAC_W]}) * 34'(MOD_RECIP);
			nlo_s2  <= lon_arg[32:FRAC_W];
			flo_s2  <= lon_arg[FRAC_W-1:0];
			plo_s2  <= 34'(lon_arg[32:FRAC_W]) * 34'(MOD_RECIP);
			lt_s2   <= lt1;
			gt_s2   <= gt1;
			fold_s2 <= fold1;
			lat_s2  <= lat_s1;
			lon_s2  <= lon_s1;
			// s3
			ma_s3   <= {rla[8:0], fla_s2};
			mo_s3   <= {rlo[8:0], flo_s2};
			lt_s3   <= lt_s2;
			gt_s3   <= gt_s2;
			fold_s3 <= fold_s2;
			lat_s3  <= lat_s2;
			lon_s3  <= lon_s2;
			// s4
			lato_s4 <= lat_off[23:0];
			lonf_s4 <= lon_f;
			// s5: scaled position, half a cell added for nearest
			u_s5 <= 32'(lato_s4) * 32'(dims.lat_span) + (near4 ? 32'(DEG90) : 32'd0);
			v_s5 <= 34'(lonf_s4) * 34'(dims.lon_span) + (near4 ? 34'(DEG180) : 34'd0);
			// s6
			nu_s6 <= u_s5[31:FRAC_W];
			fu_s6 <= u_s5[FRAC_W-1:0];
			pu_s6 <= 33'(u_s5[31:FRAC_W]) * 33'(MOD_RECIP);
			nv_s6 <= v_s5[33:FRAC_W];
			fv_s6 <= v_s5[FRAC_W-1:0];
			pv_s6 <= 35'(v_s5[33:FRAC_W]) * 35'(MOD_RECIP);
			// s7: indices clamped at the last row and column
			ilat_s7 <= (qu > 9'(dims.lat_span)) ? dims.lat_span : qu[ROW_W-1:0];
			ilon_s7 <= (qv > 10'(dims.lon_span)) ? dims.lon_span : qv[COL_W-1:0];
			remu_s7 <= {ru[7:0], fu_s6};
			remv_s7 <= {rv[8:0], fv_s6};
			// s8: weights as reciprocal products
			wlp_s8 <= 49'(remu_s7) * 49'(W_RECIP180);
			wop_s8 <= 51'(remv_s7) * 51'(W_RECIP360);
			// s9: blend along longitude
			p00_s9 <= 49'(rd_data[0]) * 49'(woc8);
			p01_s9 <= 49'(rd_data[1]) * 49'(wo8);
			p10_s9 <= 49'(rd_data[2]) * 49'(woc8);
			p11_s9 <= 49'(rd_data[3]) * 49'(wo8);
			wl_s9  <= wl8;
			d0_s9  <= rd_data[0];
			// s10
			r0_s10 <= s0[FRAC_W +: RADIUS_W];
			r1_s10 <= s1[FRAC_W +: RADIUS_W];
			wl_s10 <= wl_s9;
			d0_s10 <= d0_s9;
			// s11: blend along latitude
			q0_s11 <= 49'(r0_s10) * 49'((FRAC_W+1)'(UNIT) - (FRAC_W+1)'(wl_s10));
			q1_s11 <= 49'(r1_s10) * 49'(wl_s10);
			d0_s11 <= d0_s10;
			// output
			radius_q <= res11;
		end
	end

endmodule

// ----- hw/rtl/latlon_grid_radius_interpolator.sv -----
// Top level of the lat/lon radius grid interpolator.
`timescale 1ns / 1ps
// Usage
//   Input channel (item_valid / item_stall): one transaction per command.
//   command 0 writes sample_value at (row_index, column_index); 1 is a
//   bilinear query and 2 a nearest-neighbour query on lat_angle/lon_angle
//   (signed Q16.16 degrees); 3 is taken and ignored.
//   Output channel (result_valid / result_stall): one radius_out (unsigned
//   Q16.16) per query, in order; writes give none.
//   Config port: cfg_write with cfg_index 0 sets lat_points, 1 lon_points.
//   Write only while idle.
// Timing
//   One transaction per cycle, sustained, for any mix of commands, while
//   result_stall is low. A query passes the front register, the 4-entry queue,
//   the 11-stage lookup pipeline and the output register to result_valid.
//   A write reaches the grid store at stage 7 of the lookup pipeline; later
//   queries always see it.
//   While result_stall holds a result, the lookup pipeline freezes; the
//   front keeps accepting until the queue and front register fill.
// Reset
//   arst_n clears all handshake state; lat_points and lon_points return to 2.
//   The grid store is not cleared: read only entries that have been written.
module latlon_grid_radius_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          command,
	input  logic signed [lgri_pkg::ANGLE_W-1:0] lat_angle,
	input  logic signed [lgri_pkg::ANGLE_W-1:0] lon_angle,
	input  logic [lgri_pkg::ROW_W-1:0]          row_index,
	input  logic [lgri_pkg::COL_W-1:0]          column_index,
	input  logic [lgri_pkg::RADIUS_W-1:0]       sample_value,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [lgri_pkg::RADIUS_W-1:0]       radius_out,
	input  logic                                cfg_write,
	input  logic [lgri_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lgri_pkg::CFG_W-1:0]          cfg_data
);
	import lgri_pkg::*;

	logic [LAT_PTS_W-1:0] lat_points_q;
	logic [LON_PTS_W-1:0] lon_points_q;
	dims_t dims;
	item_t push_item, head;
	logic  push, full, pop, empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_points_q <= LAT_PTS_W'(2);
			lon_points_q <= LON_PTS_W'(2);
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_LAT_POINTS: lat_points_q <= cfg_data[LAT_PTS_W-1:0];
				REG_LON_POINTS: lon_points_q <= cfg_data[LON_PTS_W-1:0];
				default: ;
			endcase
		end
	end

	// counts saturate to [2, max]; the pipeline works with count minus one
	always_comb begin
		if (lat_points_q < LAT_PTS_W'(2)) begin
			dims.lat_span = ROW_W'(1);
		end else if (lat_points_q > LAT_PTS_W'(MAX_ROWS)) begin
			dims.lat_span = ROW_W'(MAX_ROWS - 1);
		end else begin
			dims.lat_span = ROW_W'(lat_points_q - LAT_PTS_W'(1));
		end
		if (lon_points_q < LON_PTS_W'(2)) begin
			dims.lon_span = COL_W'(1);
		end else if (lon_points_q > LON_PTS_W'(MAX_COLUMNS)) begin
			dims.lon_span = COL_W'(MAX_COLUMNS - 1);
		end else begin
			dims.lon_span = COL_W'(lon_points_q - LON_PTS_W'(1));
		end
	end

	lgri_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.command     (command),
		.lat_angle   (lat_angle),
		.lon_angle   (lon_angle),
		.row_index   (row_index),
		.column_index(column_index),
		.sample_value(sample_value),
		.push        (push),
		.push_item   (push_item),
		.q_full      (full)
	);

	lgri_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	lgri_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_item      (head),
		.q_empty     (empty),
		.q_pop       (pop),
		.dims        (dims),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.radius_out  (radius_out)
	);

endmodule

// ----- hw/rtl/lgri_checker.sv -----
// Port-level assertions for the interpolator, bound to the top level.
`timescale 1ns / 1ps
module lgri_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [lgri_pkg::RADIUS_W-1:0] radius_out
);

	// front only backs up after it has just taken a transaction
	a_stall_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("item_stall rose without a transaction taken");

	// both channels come out of reset quiet
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> (!result_valid && !item_stall))
		else $error("channel active straight after reset");

	// a held result keeps its value
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(radius_out)))
		else $error("stalled result dropped or changed");

endmodule

bind latlon_grid_radius_interpolator lgri_checker u_lgri_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.radius_out  (radius_out)
);

// ----- tb/sv/tb.sv -----
// Testbench for the lat/lon radius grid interpolator: scoreboard, stimulus and checks.
`timescale 1ns / 1ps
module tb;
	import lgri_pkg::*;

	// ---------------------------------------------------------------
	// Fixed-point constants used by the radius predictor
	// ---------------------------------------------------------------
	localparam longint P_UNIT = 64'sd1 << FRAC_W;
	localparam longint P_D90  = 90 * P_UNIT;
	localparam longint P_D180 = 180 * P_UNIT;
	localparam longint P_D360 = 360 * P_UNIT;
	// pole tolerance: 90 degrees plus 0.01 degree rounded onto the grid
	localparam longint P_TOL  = P_D90 + (P_UNIT + 50) / 100;

	// cycles without any transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 5000;
	// settle time after the last expected radius (query latency plus margin)
	localparam int DRAIN_CYCLES   = 40;

	// ---------------------------------------------------------------
	// Scoreboard: shadow grid, shadow registers, queue of predicted radii
	// ---------------------------------------------------------------
	class radius_scoreboard;
		bit [RADIUS_W-1:0] grid [MAX_ROWS][MAX_COLUMNS];
		bit                written [MAX_ROWS][MAX_COLUMNS];
		bit [LAT_PTS_W-1:0] lat_pts;
		bit [LON_PTS_W-1:0] lon_pts;
		bit [RADIUS_W-1:0] pending_radii [$];
		int                fails;

		function new();
			lat_pts = 2;
			lon_pts = 2;
			fails   = 0;
		endfunction

		function int rows_used();
			if (lat_pts < 2) return 2;
			if (lat_pts > MAX_ROWS) return MAX_ROWS;
			return lat_pts;
		endfunction

		function int cols_used();
			if (lon_pts < 2) return 2;
			if (lon_pts > MAX_COLUMNS) return MAX_COLUMNS;
			return lon_pts;
		endfunction

		function longint unsigned blend(longint unsigned a, longint unsigned b,
				longint unsigned w);
			longint unsigned s;
			s = a * (P_UNIT - w) + b * w;
			return (s + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		endfunction

		function bit [RADIUS_W-1:0] lookup_radius(cmd_t cmd, logic signed [31:0] lat_in,
				logic signed [31:0] lon_in);
			longint lat, lon, m;
			longint unsigned su, sv, wl, wo, r0, r1;
			int nlat, nlon, ila, ilo, ila1, ilo1;
			lat  = lat_in;
			lon  = lon_in;
			nlat = rows_used();
			nlon = cols_used();
			if (lat < -P_D90 || lat > P_D90 || lon < 0 || lon > P_D360) begin
				if (lat < -P_TOL) lat += P_D360 * (1 + (P_D90 - lat) / P_D360);
				if (lat > P_TOL) lat -= P_D360 * (1 + (lat - P_D90) / P_D360);
				// reflect over a pole: longitude swings round by half a turn
				if (lat < -P_TOL) begin
					lat = -P_D180 - lat;
					lon += P_D180;
				end
				if (lat > P_TOL) begin
					lat = P_D180 - lat;
					lon += P_D180;
				end
				m = lon % P_D360;
				if (m < 0) m += P_D360;
				lon = m;
			end
			if (lat < -P_D90) lat = -P_D90;
			if (lat > P_D90) lat = P_D90;
			su = longint'(lat + P_D90) * (nlat - 1);
			sv = longint'(lon) * (nlon - 1);
			if (cmd == CMD_NEAREST) begin
				ila = int'((su + P_D180 / 2) / P_D180);
				ilo = int'((sv + P_D360 / 2) / P_D360);
				if (ila >= nlat) ila = nlat - 1;
				if (ilo >= nlon) ilo = nlon - 1;
				return grid[ila][ilo];
			end
			ila = int'(su / P_D180);
			ilo = int'(sv / P_D360);
			if (ila >= nlat) ila = nlat - 1;
			if (ilo >= nlon) ilo = nlon - 1;
			wl   = ((su % P_D180) << FRAC_W) / P_D180;
			wo   = ((sv % P_D360) << FRAC_W) / P_D360;
			ila1 = (ila < nlat - 1) ? ila + 1 : ila;
			ilo1 = (ilo < nlon - 1) ? ilo + 1 : ilo;
			r0 = blend(grid[ila][ilo], grid[ila][ilo1], wo);
			r1 = blend(grid[ila1][ilo], grid[ila1][ilo1], wo);
			return RADIUS_W'(blend(r0, r1, wl));
		endfunction

		// accepted input transaction
		function void note_item(cmd_t cmd, logic signed [31:0] lat, logic signed [31:0] lon,
				logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic [RADIUS_W-1:0] val);
			case (cmd)
				CMD_WRITE: begin
					grid[row][col]    = val;
					written[row][col] = 1'b1;
				end
				CMD_BILINEAR, CMD_NEAREST: pending_radii.push_back(lookup_radius(cmd, lat, lon));
				default: ;
			endcase
		endfunction

		task report(string what, bit [RADIUS_W-1:0] got, bit [RADIUS_W-1:0] want);
			$display("MISMATCH %s: radius_out got %h want %h at %0t", what, got, want, $time);
			fails++;
		endtask

		// accepted output transaction
		task check_radius(logic [RADIUS_W-1:0] got);
			bit [RADIUS_W-1:0] want;
			if (pending_radii.size() == 0) begin
				report("unexpected result", got, '0);
			end else begin
				want = pending_radii.pop_front();
				if (got !== want) report("wrong radius", got, want);
			end
		endtask
	endclass

	// ---------------------------------------------------------------
	// DUT signals
	// ---------------------------------------------------------------
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic [1:0]              command = CMD_WRITE;
	logic signed [ANGLE_W-1:0] lat_angle = '0;
	logic signed [ANGLE_W-1:0] lon_angle = '0;
	logic [ROW_W-1:0]        row_index = '0;
	logic [COL_W-1:0]        column_index = '0;
	logic [RADIUS_W-1:0]     sample_value = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [RADIUS_W-1:0]     radius_out;
	logic                    cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_LAT_POINTS;
	logic [CFG_W-1:0]        cfg_data = '0;

	latlon_grid_radius_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .lat_angle(lat_angle), .lon_angle(lon_angle),
		.row_index(row_index), .column_index(column_index), .sample_value(sample_value),
		.result_valid(result_valid), .result_stall(result_stall), .radius_out(radius_out),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	radius_scoreboard sb = new();
	bit quiet_mode = 1'b0;   // when set, neither side idles
	int idle_cycles = 0;

	// ---------------------------------------------------------------
	// Monitors: both sample pre-edge values at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_item(cmd_t'(command), lat_angle, lon_angle, row_index, column_index,
				sample_value);
		if (arst_n && result_valid && !result_stall)
			sb.check_radius(radius_out);
	end

	// Watchdog: counts cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// random gap length: mostly short, now and then long
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 55) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	// Receiver back-pressure: runs of stall/no-stall of random length
	int stall_hold = 0;
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (quiet_mode || $urandom_range(0, 99) < 60) begin
			result_stall <= 1'b0;
			stall_hold   <= $urandom_range(0, 8);
		end else begin
			result_stall <= 1'b1;
			stall_hold   <= pick_gap();
		end
	end

	// ---------------------------------------------------------------
	// Driver tasks
	// ---------------------------------------------------------------
	task send_item(cmd_t cmd, logic signed [31:0] lat, logic signed [31:0] lon,
			logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic [RADIUS_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command      <= cmd;
		lat_angle    <= lat;
		lon_angle    <= lon;
		row_index    <= row;
		column_index <= col;
		sample_value <= val;
		item_valid   <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	task send_query(cmd_t cmd, logic signed [31:0] lat, logic signed [31:0] lon);
		send_item(cmd, lat, lon, ROW_W'($urandom), COL_W'($urandom), $urandom);
	endtask

	// wait until every predicted radius has come back, then let the pipe settle
	task wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_radii.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_reg(reg_idx_t idx, int value);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_LAT_POINTS) sb.lat_pts = LAT_PTS_W'(value);
		else sb.lon_pts = LON_PTS_W'(value);
		@(posedge clk);
	endtask

	// load every entry the current grid extent can read that was never written
	task fill_grid();
		for (int r = 0; r < sb.rows_used(); r++)
			for (int c = 0; c < sb.cols_used(); c++)
				if (!sb.written[r][c])
					send_item(CMD_WRITE, $urandom, $urandom, ROW_W'(r), COL_W'(c),
						$urandom);
	endtask

	// latitude/longitude with weight on boundaries, in-range values and wild ones
	function logic signed [31:0] pick_angle(bit is_lat);
		int r;
		longint base;
		r = $urandom_range(0, 99);
		base = is_lat ? P_D90 : P_D360;
		if (r < 50) return is_lat ? 32'($urandom_range(0, 2 * P_D90) - P_D90)
			: 32'($urandom_range(0, P_D360));
		if (r < 60) return 32'(base + $urandom_range(0, 1400) - 700);
		if (r < 65) return 32'(-base + $urandom_range(0, 1400) - 700);
		if (r < 75) return 32'($urandom_range(0, 4000 * P_UNIT) - 2000 * P_UNIT);
		if (r < 80) return 32'($urandom_range(0, 8) - 4);
		return $urandom;
	endfunction

	task random_items(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				send_item(CMD_WRITE, $urandom, $urandom, ROW_W'($urandom),
					COL_W'($urandom), $urandom);
			else if (r < 15)
				send_item(CMD_NONE, $urandom, $urandom, ROW_W'($urandom),
					COL_W'($urandom), $urandom);
			else
				send_query((r < 57) ? CMD_BILINEAR : CMD_NEAREST,
					pick_angle(1'b1), pick_angle(1'b0));
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	int lat_settings [6] = '{0, 3, 128, 255, 17, 1};
	int lon_settings [6] = '{1, 5, 2, 3, 6, 511};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset extent of 2x2, boundaries and special cases
		quiet_mode = 1'b1;
		fill_grid();
		send_item(CMD_WRITE, 0, 0, ROW_W'(0), COL_W'(0), 32'hFFFF_FFFF);
		send_item(CMD_WRITE, 0, 0, ROW_W'(1), COL_W'(1), 32'h0000_0000);
		send_item(CMD_WRITE, 0, 0, ROW_W'(127), COL_W'(255), 32'h1234_5678); // unused by queries
		send_item(CMD_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 7'h7F, 8'hFF, 32'hFFFF_FFFF);
		send_query(CMD_BILINEAR, 0, 0);
		send_query(CMD_BILINEAR, 32'(P_D90), 32'(P_D360));       // 360 with no folding
		send_query(CMD_NEAREST, 32'(-P_D90), 32'(P_D360));
		send_query(CMD_BILINEAR, 32'(P_TOL), 32'(45 * P_UNIT));    // inside pole tolerance
		send_query(CMD_BILINEAR, 32'(P_TOL + 1), 32'(45 * P_UNIT)); // reflected over north pole
		send_query(CMD_NEAREST, 32'(-P_TOL - 1), 32'(45 * P_UNIT)); // reflected over south pole
		send_query(CMD_NEAREST, 32'(-P_TOL), -1);
		send_query(CMD_BILINEAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_query(CMD_BILINEAR, 32'h8000_0000, 32'h8000_0000);
		send_query(CMD_NEAREST, 32'h7FFF_FFFF, 32'h8000_0000);
		send_query(CMD_NEAREST, 0, 32'(P_D180));                  // half-way column
		send_query(CMD_BILINEAR, 0, 32'(P_D360 + 1));
		send_query(CMD_BILINEAR, 32'(450 * P_UNIT), -1);
		quiet_mode = 1'b0;

		// random phases across register settings, extremes included
		foreach (lat_settings[p]) begin
			write_reg(REG_LAT_POINTS, lat_settings[p]);
			write_reg(REG_LON_POINTS, lon_settings[p]);
			quiet_mode = (p == 2);
			fill_grid();
			quiet_mode = 1'b0;
			random_items(135);
		end

		wait_idle();
		if (sb.fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/lgri_pkg.sv
hw/rtl/lgri_ram.sv
hw/rtl/lgri_front.sv
hw/rtl/lgri_queue.sv
hw/rtl/lgri_back.sv
hw/rtl/latlon_grid_radius_interpolator.sv
hw/rtl/lgri_checker.sv
tb/sv/tb.sv
